// ===== rtl/bmp_unpk_pkg.sv =====
// ----------------------------------------------------------------------------
// bmp_unpk_pkg
// Shared types and codes of the bitmap pixel row unpacker: pixel formats,
// register indexes and the command that the front part hands to the back.
// ----------------------------------------------------------------------------
package bmp_unpk_pkg;

    // widths of the configuration and position fields
    localparam int DIM_W   = 13;
    localparam int POS_W   = 12;
    localparam int RBC_W   = 15;
    localparam int CFG_IDX_W = 2;
    localparam int DIM_CAP = 8191;

    // pixel format codes
    localparam logic [2:0] FMT_1BPP  = 3'd0;
    localparam logic [2:0] FMT_4BPP  = 3'd1;
    localparam logic [2:0] FMT_8BPP  = 3'd2;
    localparam logic [2:0] FMT_16BPP = 3'd3;
    localparam logic [2:0] FMT_24BPP = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    // command kinds
    localparam logic [1:0] CMD_PAL_WR  = 2'd0;
    localparam logic [1:0] CMD_INDEXED = 2'd1;
    localparam logic [1:0] CMD_DIRECT  = 2'd2;

    // palette store
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW = $clog2(PALETTE_DEPTH);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    // one classified item: a palette write or a run of one to eight pixels
    typedef struct packed {
        logic [1:0]        kind;
        logic [2:0]        fmt;
        logic [23:0]       payload;
        logic [PAL_AW-1:0] pal_addr;
        logic [2:0]        cnt_m1;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
        logic              eor;
        logic              eoi;
    } t_cmd;

endpackage

// ===== rtl/bmp_unpk_front.sv =====
// ----------------------------------------------------------------------------
// bmp_unpk_front
// Holds the registers and the stream position, takes one accepted input item a
// cycle and turns it into a palette write command, a pixel run command or none.
// ----------------------------------------------------------------------------
module bmp_unpk_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [bmp_unpk_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bmp_unpk_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                               i_accept,
    input  logic                               i_mode,
    input  logic [7:0]                         i_pal_index,
    input  logic [23:0]                        i_pal_color,
    input  logic [7:0]                         i_data_byte,
    output logic                               o_push,
    output bmp_unpk_pkg::t_cmd                 o_cmd
);
    import bmp_unpk_pkg::*;

    localparam int W_CAP = (MAX_WIDTH > DIM_CAP) ? DIM_CAP : MAX_WIDTH;
    localparam int H_CAP = (MAX_HEIGHT > DIM_CAP) ? DIM_CAP : MAX_HEIGHT;
    localparam logic [DIM_W-1:0] W_CAP_V = DIM_W'(W_CAP);
    localparam logic [DIM_W-1:0] H_CAP_V = DIM_W'(H_CAP);

    logic [2:0]       r_fmt, n_fmt;
    logic [DIM_W-1:0] r_width, n_width;
    logic [DIM_W-1:0] r_height, n_height;
    logic [DIM_W-1:0] r_col, n_col;
    logic [DIM_W-1:0] r_row, n_row;
    logic [RBC_W-1:0] r_rbc, n_rbc;
    logic [15:0]      r_held, n_held;
    logic [1:0]       r_phase, n_phase;

    logic [DIM_W-1:0] w, h, w_rem, per, cnt, col_next;
    logic [RBC_W-1:0] data_bytes, scan, rbc_inc;
    logic [15:0]      word;
    logic             col_ok, emit;

    // clamped dimensions and row geometry
    always_comb begin
        w = (r_width == '0) ? DIM_W'(1) : ((r_width > W_CAP_V) ? W_CAP_V : r_width);
        h = (r_height == '0) ? DIM_W'(1) : ((r_height > H_CAP_V) ? H_CAP_V : r_height);
        case (r_fmt)
            FMT_1BPP:  data_bytes = ({2'b00, w} + RBC_W'(7)) >> 3;
            FMT_4BPP:  data_bytes = ({2'b00, w} + RBC_W'(1)) >> 1;
            FMT_8BPP:  data_bytes = {2'b00, w};
            FMT_16BPP: data_bytes = {1'b0, w, 1'b0};
            default:   data_bytes = {2'b00, w} + {1'b0, w, 1'b0};
        endcase
        scan = (data_bytes + RBC_W'(3)) & ~RBC_W'(3);
        case (r_fmt)
            FMT_1BPP: per = DIM_W'(8);
            FMT_4BPP: per = DIM_W'(2);
            default:  per = DIM_W'(1);
        endcase
        col_ok   = r_col < w;
        w_rem    = w - r_col;
        cnt      = (w_rem > per) ? per : w_rem;
        col_next = r_col + cnt;
        word     = {i_data_byte, r_held[7:0]};
        rbc_inc  = r_rbc + RBC_W'(1);
    end

    // next state and command build
    always_comb begin
        n_fmt    = r_fmt;
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        n_rbc    = r_rbc;
        n_held   = r_held;
        n_phase  = r_phase;
        emit     = 1'b0;
        o_push   = 1'b0;
        o_cmd.kind     = CMD_INDEXED;
        o_cmd.fmt      = r_fmt;
        o_cmd.payload  = {16'h0000, i_data_byte};
        o_cmd.pal_addr = i_pal_index;
        o_cmd.cnt_m1   = 3'd0;
        o_cmd.col      = r_col[POS_W-1:0];
        o_cmd.row      = r_row[POS_W-1:0];
        o_cmd.eor      = 1'b0;
        o_cmd.eoi      = 1'b0;

        if (i_cfg_valid) begin
            // a mapped register write restarts the stream
            case (i_cfg_index)
                REG_PIXEL_FORMAT: n_fmt = i_cfg_data[2:0];
                REG_IMAGE_WIDTH:  n_width = i_cfg_data;
                REG_IMAGE_HEIGHT: n_height = i_cfg_data;
                default: ;
            endcase
            if (i_cfg_index inside {REG_PIXEL_FORMAT, REG_IMAGE_WIDTH,
                                    REG_IMAGE_HEIGHT}) begin
                n_col   = '0;
                n_row   = '0;
                n_rbc   = '0;
                n_held  = '0;
                n_phase = '0;
            end
        end else if (i_accept && !i_mode) begin
            o_push        = 1'b1;
            o_cmd.kind    = CMD_PAL_WR;
            o_cmd.payload = i_pal_color;
        end else if (i_accept) begin
            if (r_rbc < data_bytes && r_row < h) begin
                case (r_fmt)
                    FMT_1BPP, FMT_4BPP, FMT_8BPP: begin
                        emit = col_ok;
                    end
                    FMT_16BPP: begin
                        if (r_phase == 2'd0) begin
                            n_held  = {8'h00, i_data_byte};
                            n_phase = 2'd1;
                        end else begin
                            n_held  = '0;
                            n_phase = 2'd0;
                            emit    = col_ok;
                            o_cmd.kind    = CMD_DIRECT;
                            o_cmd.payload = {word[14:10], 3'b000, word[9:5], 3'b000,
                                             word[4:0], 3'b000};
                        end
                    end
                    default: begin
                        if (r_phase == 2'd0) begin
                            n_held  = {8'h00, i_data_byte};
                            n_phase = 2'd1;
                        end else if (r_phase == 2'd1) begin
                            n_held  = {i_data_byte, r_held[7:0]};
                            n_phase = 2'd2;
                        end else begin
                            n_held  = '0;
                            n_phase = 2'd0;
                            emit    = col_ok;
                            o_cmd.kind    = CMD_DIRECT;
                            o_cmd.payload = {i_data_byte, r_held[15:8], r_held[7:0]};
                        end
                    end
                endcase
                if (emit) begin
                    o_push       = 1'b1;
                    o_cmd.cnt_m1 = (o_cmd.kind == CMD_DIRECT) ? 3'd0 : 3'(cnt - DIM_W'(1));
                    n_col        = (o_cmd.kind == CMD_DIRECT) ? r_col + DIM_W'(1) : col_next;
                    o_cmd.eor    = (n_col == w);
                    o_cmd.eoi    = (n_col == w) && (r_row == h - DIM_W'(1));
                end
            end
            // row end after the last padding byte
            n_rbc = rbc_inc;
            if (rbc_inc >= scan) begin
                n_rbc   = '0;
                n_col   = '0;
                n_held  = '0;
                n_phase = '0;
                n_row   = (r_row + DIM_W'(1) >= h) ? '0 : r_row + DIM_W'(1);
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_24BPP;
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_col    <= '0;
            r_row    <= '0;
            r_rbc    <= '0;
            r_held   <= '0;
            r_phase  <= '0;
        end else begin
            r_fmt    <= n_fmt;
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_rbc    <= n_rbc;
            r_held   <= n_held;
            r_phase  <= n_phase;
        end
    end

endmodule

// ===== rtl/bmp_unpk_queue.sv =====
// ----------------------------------------------------------------------------
// bmp_unpk_queue
// Short first-in first-out queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module bmp_unpk_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bmp_unpk_pkg::t_cmd i_data,
    input  logic               i_pop,
    output logic               o_valid,
    output logic               o_full,
    output bmp_unpk_pkg::t_cmd o_data
);
    import bmp_unpk_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push, do_pop;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            if (do_pop) r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

// ===== rtl/bmp_unpk_back.sv =====
// ----------------------------------------------------------------------------
// bmp_unpk_back
// Carries out commands: writes the palette, expands pixel runs one pixel a
// cycle unless the output stalls; looks colors up and registers the result.
// ----------------------------------------------------------------------------
module bmp_unpk_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  bmp_unpk_pkg::t_cmd               i_q_data,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [31:0]                      o_argb,
    output logic [bmp_unpk_pkg::POS_W-1:0]   o_col,
    output logic [bmp_unpk_pkg::POS_W-1:0]   o_row,
    output logic                             o_eor,
    output logic                             o_eoi,
    output logic                             o_last
);
    import bmp_unpk_pkg::*;

    logic [23:0]       r_pal [PALETTE_DEPTH];
    logic [23:0]       r_pal_q;

    logic              r_cur_valid;
    t_cmd              r_cur;
    logic [2:0]        r_pix;

    logic              r_s1_valid, r_s1_direct, r_s1_eor, r_s1_eoi, r_s1_last;
    logic [23:0]       r_s1_rgb;
    logic [POS_W-1:0]  r_s1_col, r_s1_row;

    logic              r_out_valid, r_out_eor, r_out_eoi, r_out_last;
    logic [31:0]       r_out_argb;
    logic [POS_W-1:0]  r_out_col, r_out_row;

    logic              is_wr, out_open, s1_move, s1_open, issue, last_pix, done, take;
    logic [PAL_AW-1:0] rd_idx;
    logic [7:0]        cur_byte;

    // pipeline flow control
    assign is_wr    = r_cur.kind == CMD_PAL_WR;
    assign out_open = !r_out_valid || i_ready;
    assign s1_move  = r_s1_valid && out_open;
    assign s1_open  = !r_s1_valid || s1_move;
    assign issue    = r_cur_valid && !is_wr && s1_open;
    assign last_pix = r_pix == r_cur.cnt_m1;
    assign done     = r_cur_valid && (is_wr || (issue && last_pix));
    assign take     = !r_cur_valid || done;
    assign o_pop    = take && i_q_valid;

    // palette index of the pixel being issued, first pixel in the high bits
    always_comb begin
        cur_byte = r_cur.payload[7:0];
        case (r_cur.fmt)
            FMT_1BPP: rd_idx = {7'b0000000, cur_byte[3'd7 - r_pix]};
            FMT_4BPP: rd_idx = (r_pix == 3'd0) ? {4'h0, cur_byte[7:4]}
                                               : {4'h0, cur_byte[3:0]};
            default:  rd_idx = cur_byte;
        endcase
    end

    // current command and pixel counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_pix       <= '0;
        end else if (take) begin
            r_cur_valid <= i_q_valid;
            r_pix       <= '0;
        end else if (issue) begin
            r_pix <= r_pix + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_cur <= i_q_data;
    end

    // palette memory, registered read
    always_ff @(posedge i_clk) begin
        if (r_cur_valid && is_wr) r_pal[r_cur.pal_addr] <= r_cur.payload;
        if (issue) r_pal_q <= r_pal[rd_idx];
    end

    // lookup stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_open) begin
            r_s1_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_direct <= r_cur.kind == CMD_DIRECT;
            r_s1_rgb    <= r_cur.payload;
            r_s1_col    <= r_cur.col + POS_W'(r_pix);
            r_s1_row    <= r_cur.row;
            r_s1_eor    <= r_cur.eor && last_pix;
            r_s1_eoi    <= r_cur.eoi && last_pix;
            r_s1_last   <= last_pix;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_open) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_argb <= {8'hFF, r_s1_direct ? r_s1_rgb : r_pal_q};
            r_out_col  <= r_s1_col;
            r_out_row  <= r_s1_row;
            r_out_eor  <= r_s1_eor;
            r_out_eoi  <= r_s1_eoi;
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_argb  = r_out_argb;
    assign o_col   = r_out_col;
    assign o_row   = r_out_row;
    assign o_eor   = r_out_eor;
    assign o_eoi   = r_out_eoi;
    assign o_last  = r_out_last;

endmodule

// ===== rtl/bmp_pixel_row_unpacker.sv =====
// ----------------------------------------------------------------------------
// bmp_pixel_row_unpacker
// Turns bitmap pixel-array bytes into opaque 0xFFRRGGBB pixels with position.
// ----------------------------------------------------------------------------
// The block takes one input item per cycle while its four-entry command queue
// has room and no register write is offered; a data byte becomes at most one
// command, a palette write one command. The back end emits one pixel per cycle
// while the output is not stalled; at 1 bpp a byte gives up to eight pixels, at
// 4 bpp up to two, at 8 bpp one, at 16 bpp two bytes make one pixel and at 24
// bpp three bytes make one pixel; row padding bytes give no pixels. A palette
// write gives no pixel. A byte's pixels pass the queue, the current command
// register, the lookup stage and the output register in that order.
// Palette entries must be written before they are used.
// ----------------------------------------------------------------------------
module bmp_pixel_row_unpacker #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // register write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bmp_unpk_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bmp_unpk_pkg::DIM_W-1:0]     i_cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [39:0]                        s_axis_tdata,  // palette_index, palette_color, data_byte
    input  logic                               s_axis_tuser,  // mode
    // pixel stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [55:0]                        m_axis_tdata,  // pixel_argb, pixel_column, pixel_row
    output logic [1:0]                         m_axis_tuser,  // end_of_row, end_of_image
    output logic                               m_axis_tlast   // last_of_run
);
    import bmp_unpk_pkg::*;

    logic             q_full, q_valid, q_pop, push, accept;
    t_cmd             push_cmd, q_cmd;
    logic [31:0]      argb;
    logic [POS_W-1:0] col, row;
    logic             eor, eoi;

    // a register write takes the cycle, so no request is taken beside it
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !q_full && !i_cfg_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // classify requests and track the stream position
    bmp_unpk_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_mode      (s_axis_tuser),
        .i_pal_index (s_axis_tdata[7:0]),
        .i_pal_color (s_axis_tdata[31:8]),
        .i_data_byte (s_axis_tdata[39:32]),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // command queue
    bmp_unpk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_cmd)
    );

    // palette and pixel expansion
    bmp_unpk_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_cmd),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_argb    (argb),
        .o_col     (col),
        .o_row     (row),
        .o_eor     (eor),
        .o_eoi     (eoi),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {row, col, argb};
    assign m_axis_tuser = {eoi, eor};

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench for bmp_pixel_row_unpacker
// Streams palette writes and pixel-array bytes into the unpacker under random
// sender gaps and receiver stalls. A behavioral copy of the unpacker predicts
// every pixel, and each pixel that leaves the block is compared field by field.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import bmp_unpk_pkg::*;

    localparam int MAX_W          = 4096;
    localparam int MAX_H          = 4096;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 32;
    localparam int WIDE_ROW_BYTES = 64;

    localparam logic       MODE_PALETTE    = 1'b0;
    localparam logic       MODE_PIXEL      = 1'b1;
    localparam logic [2:0] FMT_UNUSED_LAST = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam logic [7:0] ALPHA_OPAQUE    = 8'hFF;

    // receiver stall styles
    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_SPARSE  = 2;
    localparam int RX_PATTERN = 3;

    typedef struct packed {
        logic [31:0]      argb;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             eor;
        logic             eoi;
        logic             lor;
    } t_pixel;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0] cfg_data;
    logic             s_valid;
    logic             s_axis_tready;
    logic [39:0]      s_data;
    logic             s_user;
    logic             m_axis_tvalid;
    logic             m_ready;
    logic [55:0]      m_axis_tdata;
    logic [1:0]       m_axis_tuser;
    logic             m_axis_tlast;

    // predictor state
    logic [23:0]      pal_rgb [PALETTE_DEPTH];
    bit               pal_loaded [PALETTE_DEPTH];
    logic [2:0]       fmt_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    int               col_pos;
    int               row_pos;
    int               row_bytes;
    logic [15:0]      held;
    int               phase;
    int               cur_w, cur_h, cur_bpp, cur_data_bytes, cur_scan;

    t_pixel           pending_pixels [$];
    t_pixel           want_px;

    int               mismatches     = 0;
    int               pixels_checked = 0;
    int               items_sent     = 0;
    int               idle_cycles    = 0;
    int               burst_left     = 0;
    bit               sender_gaps    = 1'b0;
    int               stall_mode     = RX_ALWAYS;
    int               holdoff_left   = 0;
    int               rx_tick        = 0;

    bmp_pixel_row_unpacker #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),   // palette_index, palette_color, data_byte
        .s_axis_tuser  (s_user),   // mode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),  // pixel_argb, pixel_column, pixel_row
        .m_axis_tuser  (m_axis_tuser),  // end_of_row, end_of_image
        .m_axis_tlast  (m_axis_tlast)   // last_of_run
    );

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic int clamp_dim(input int v, input int maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // row geometry follows every register change
    function automatic void update_geometry();
        cur_w = clamp_dim(int'(width_reg), MAX_W);
        cur_h = clamp_dim(int'(height_reg), MAX_H);
        case (fmt_reg)
            FMT_1BPP:  cur_bpp = 1;
            FMT_4BPP:  cur_bpp = 4;
            FMT_8BPP:  cur_bpp = 8;
            FMT_16BPP: cur_bpp = 16;
            default:   cur_bpp = 24;
        endcase
        cur_data_bytes = (cur_w * cur_bpp + 7) / 8;
        cur_scan = (cur_data_bytes + 3) & ~3;
    endfunction

    // any mapped register write restarts the stream, palette kept
    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [DIM_W-1:0] data);
        case (idx)
            REG_PIXEL_FORMAT: fmt_reg = data[2:0];
            REG_IMAGE_WIDTH:  width_reg = data;
            REG_IMAGE_HEIGHT: height_reg = data;
            default: return;
        endcase
        col_pos = 0;
        row_pos = 0;
        row_bytes = 0;
        held = '0;
        phase = 0;
        update_geometry();
    endfunction

    function automatic t_pixel make_pixel(input logic [23:0] rgb);
        t_pixel p;
        p.argb = {ALPHA_OPAQUE, rgb};
        p.col  = col_pos[POS_W-1:0];
        p.row  = row_pos[POS_W-1:0];
        p.eor  = (col_pos == cur_w - 1);
        p.eoi  = p.eor && (row_pos == cur_h - 1);
        p.lor  = 1'b0;
        return p;
    endfunction

    // one pixel-array byte: queue the pixels it yields, advance the position
    function automatic void unpack_byte(input logic [7:0] b);
        t_pixel      run_px [8];
        int          n;
        logic [7:0]  idx;
        logic [15:0] word;
        logic [23:0] rgb;
        n = 0;
        if (row_bytes < cur_data_bytes && row_pos < cur_h) begin
            if (cur_bpp == 1 || cur_bpp == 4) begin
                for (int i = 0; i < 8 / cur_bpp && col_pos < cur_w; i++) begin
                    idx = b >> (8 - cur_bpp * (i + 1));
                    idx &= (cur_bpp == 1) ? 8'h01 : 8'h0F;
                    run_px[n] = make_pixel(pal_rgb[idx]);
                    n++;
                    col_pos++;
                end
            end else if (cur_bpp == 8) begin
                if (col_pos < cur_w) begin
                    run_px[n] = make_pixel(pal_rgb[b]);
                    n++;
                    col_pos++;
                end
            end else if (cur_bpp == 16) begin
                if (phase == 0) begin
                    held = {8'h00, b};
                    phase = 1;
                end else begin
                    // little-endian 5-5-5, each field scaled by 8
                    word = {b, held[7:0]};
                    rgb = {word[14:10], 3'b000, word[9:5], 3'b000, word[4:0], 3'b000};
                    phase = 0;
                    held = '0;
                    if (col_pos < cur_w) begin
                        run_px[n] = make_pixel(rgb);
                        n++;
                        col_pos++;
                    end
                end
            end else begin
                // blue, green, red byte order
                if (phase == 0) begin
                    held = {8'h00, b};
                    phase = 1;
                end else if (phase == 1) begin
                    held[15:8] = b;
                    phase = 2;
                end else begin
                    rgb = {b, held[15:8], held[7:0]};
                    phase = 0;
                    held = '0;
                    if (col_pos < cur_w) begin
                        run_px[n] = make_pixel(rgb);
                        n++;
                        col_pos++;
                    end
                end
            end
            if (n > 0) run_px[n-1].lor = 1'b1;
        end
        for (int i = 0; i < n; i++) pending_pixels.push_back(run_px[i]);
        // end of padded row
        row_bytes++;
        if (row_bytes >= cur_scan) begin
            row_bytes = 0;
            col_pos = 0;
            held = '0;
            phase = 0;
            row_pos++;
            if (row_pos >= cur_h) row_pos = 0;
        end
    endfunction

    // true when the byte at the current position reads only loaded entries
    function automatic bit byte_hits_loaded(input logic [7:0] b);
        logic [7:0] idx;
        if (row_bytes >= cur_data_bytes || cur_bpp > 8) return 1'b1;
        if (cur_bpp == 8) return pal_loaded[b];
        for (int i = 0; i < 8 / cur_bpp && col_pos + i < cur_w; i++) begin
            idx = b >> (8 - cur_bpp * (i + 1));
            idx &= (cur_bpp == 1) ? 8'h01 : 8'h0F;
            if (!pal_loaded[idx]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // random byte, falling back to index zero which is always loaded
    function automatic logic [7:0] pick_data_byte();
        logic [7:0] b;
        repeat (16) begin
            b = 8'($urandom);
            if (byte_hits_loaded(b)) return b;
        end
        return 8'h00;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus tasks
    // ------------------------------------------------------------------------
    task automatic send_item(input logic mode, input logic [7:0] idx,
                             input logic [23:0] color, input logic [7:0] dbyte);
        int gap;
        // bursts, with random gaps when sender_gaps is set
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (sender_gaps) begin
                gap = $urandom_range(1, 6);
                @(negedge clk);
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_valid <= 1'b1;
        s_user  <= mode;
        s_data  <= {dbyte, color, idx};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        items_sent++;
        if (mode == MODE_PALETTE) begin
            pal_rgb[idx] = color;
            pal_loaded[idx] = 1'b1;
        end else begin
            unpack_byte(dbyte);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        logic [7:0]  junk_idx;
        logic [23:0] junk_color;
        junk_idx = 8'($urandom);
        junk_color = 24'($urandom);
        send_item(MODE_PIXEL, junk_idx, junk_color, b);
    endtask

    task automatic load_entry(input logic [7:0] idx, input logic [23:0] color);
        logic [7:0] junk_byte;
        junk_byte = 8'($urandom);
        send_item(MODE_PALETTE, idx, color, junk_byte);
    endtask

    // stop offering, wait for every pixel, then let the pipeline settle
    task automatic wait_drained(input int settle);
        @(negedge clk);
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        wait_drained(SETTLE_CYCLES);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        apply_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_image(input logic [DIM_W-1:0] fmt, input logic [DIM_W-1:0] w,
                             input logic [DIM_W-1:0] h);
        cfg_write(REG_PIXEL_FORMAT, fmt);
        cfg_write(REG_IMAGE_WIDTH, w);
        cfg_write(REG_IMAGE_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // every format once, partial bytes, padding, wrap, clamping
    task automatic test_directed_formats();
        sender_gaps = 1'b1;
        stall_mode = RX_RANDOM;
        load_entry(8'd0, 24'h000000);
        load_entry(8'd1, 24'hFFFFFF);
        load_entry(8'd255, 24'hA5C3E1);
        load_entry(8'd15, 24'h123456);
        // 1 bpp, three pixels from one byte, low bits ignored
        set_image(DIM_W'(FMT_1BPP), 13'd3, 13'd1);
        send_byte(8'hBF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h55);
        // 4 bpp with a palette write inside the row
        set_image(DIM_W'(FMT_4BPP), 13'd3, 13'd1);
        send_byte(8'hF0);
        load_entry(8'd2, 24'h00FF00);
        send_byte(8'h1F);
        send_byte(8'hAA);
        send_byte(8'h55);
        // 8 bpp
        set_image(DIM_W'(FMT_8BPP), 13'd1, 13'd1);
        send_byte(8'hFF);
        repeat (3) send_byte(8'h00);
        // 16 bpp, all field bits set
        set_image(DIM_W'(FMT_16BPP), 13'd1, 13'd1);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        // unknown format code behaves as 24 bpp
        set_image(DIM_W'(FMT_UNUSED_LAST), 13'd1, 13'd1);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h3C);
        // zero width and height clamp to one, unmapped index is ignored
        set_image(DIM_W'(FMT_8BPP), 13'd0, 13'd0);
        cfg_write(REG_UNMAPPED, 13'h1FFF);
        send_byte(8'h00);
        repeat (3) send_byte(8'hFF);
    endtask

    // random images of every format, mostly small sizes, under varied idling
    task automatic test_random_images();
        logic [DIM_W-1:0] fmt_word, w, h;
        logic [7:0]       r_idx;
        logic [23:0]      r_color;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            sender_gaps = (ph % 3 != 0);
            stall_mode = ph % 4;
            fmt_word = DIM_W'($urandom_range(0, 7));
            if ($urandom_range(0, 3) == 0) fmt_word[DIM_W-1:3] = (DIM_W-3)'($urandom);
            case ($urandom_range(0, 9))
                0:       w = 13'd0;
                1:       w = DIM_W'($urandom_range(25, 300));
                default: w = DIM_W'($urandom_range(1, 24));
            endcase
            h = ($urandom_range(0, 9) == 0) ? 13'h1FFF : 13'($urandom_range(0, 4));
            set_image(fmt_word, w, h);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    r_idx = 8'($urandom);
                    r_color = 24'($urandom);
                    load_entry(r_idx, r_color);
                end else begin
                    send_byte(pick_data_byte());
                end
                if ($urandom_range(0, 24) == 0) wait_drained(0);
            end
        end
    endtask

    // start of the widest row after clamping
    task automatic test_widest_row();
        sender_gaps = 1'b0;
        stall_mode = RX_PATTERN;
        set_image(DIM_W'(FMT_1BPP), 13'h1FFF, 13'h1FFF);
        repeat (WIDE_ROW_BYTES) send_byte(pick_data_byte());
    endtask

    // long receiver hold-off fills the block, then the sender waits it out
    task automatic test_backpressure();
        sender_gaps = 1'b0;
        stall_mode = RX_ALWAYS;
        set_image(DIM_W'(FMT_1BPP), 13'd32, 13'd2);
        holdoff_left = 300;
        repeat (24) send_byte(pick_data_byte());
        wait_drained(0);
        stall_mode = RX_SPARSE;
        repeat (8) send_byte(pick_data_byte());
    endtask

    // ------------------------------------------------------------------------
    // receiver ready
    // ------------------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holdoff_left > 0) begin
                m_ready <= 1'b0;
                holdoff_left--;
            end else begin
                case (stall_mode)
                    RX_RANDOM:  m_ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE:  m_ready <= ($urandom_range(0, 9) < 3);
                    RX_PATTERN: m_ready <= ((rx_tick % 16) < 11);
                    default:    m_ready <= 1'b1;
                endcase
                rx_tick++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // pixel check
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected pixel, expected none, actual %h %h %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                want_px = pending_pixels.pop_front();
                pixels_checked++;
                check_field("pixel_argb", want_px.argb, m_axis_tdata[31:0]);
                check_field("pixel_column", 32'(want_px.col), 32'(m_axis_tdata[43:32]));
                check_field("pixel_row", 32'(want_px.row), 32'(m_axis_tdata[55:44]));
                check_field("end_of_row", 32'(want_px.eor), 32'(m_axis_tuser[0]));
                check_field("end_of_image", 32'(want_px.eoi), 32'(m_axis_tuser[1]));
                check_field("last_of_run", 32'(want_px.lor), 32'(m_axis_tlast));
            end
        end
    end

    // watchdog on cycles with no request taken anywhere
    always @(posedge clk) begin
        if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_user    = MODE_PIXEL;
        s_data    = '0;
        // reset state of the predictor
        fmt_reg    = FMT_24BPP;
        width_reg  = 13'd1;
        height_reg = 13'd1;
        col_pos    = 0;
        row_pos    = 0;
        row_bytes  = 0;
        held       = '0;
        phase      = 0;
        foreach (pal_loaded[i]) begin
            pal_loaded[i] = 1'b0;
            pal_rgb[i] = '0;
        end
        update_geometry();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_formats();
        test_random_images();
        test_widest_row();
        test_backpressure();
        wait_drained(SETTLE_CYCLES);

        $display("run covered %0d requests over all pixel formats, clamped sizes,", items_sent);
        $display("padding, image wrap and forced stalls; %0d pixels checked, %0d mismatches",
                 pixels_checked, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bmp_unpk_pkg.sv
rtl/bmp_unpk_front.sv
rtl/bmp_unpk_queue.sv
rtl/bmp_unpk_back.sv
rtl/bmp_pixel_row_unpacker.sv
sim/testbench.sv
